// File: rtl/rgbspi_pkg.sv
`default_nettype none

package rgbspi_pkg;

  // default chain geometry
  localparam int LEDS_DEFAULT        = 6;
  localparam int RESET_BYTES_DEFAULT = 40;

  // one stored colour: green, red, blue
  localparam int COLOUR_W = 24;

  // twelve spi bytes per led, two colour bits each
  localparam int         BYTES_PER_LED = 12;
  localparam logic [3:0] WITHIN_FIRST  = 4'd0;
  localparam logic [3:0] WITHIN_LAST   = 4'(BYTES_PER_LED - 1);

  // line code for one colour bit
  localparam logic [3:0] BIT_ONE_CODE  = 4'd14;
  localparam logic [3:0] BIT_ZERO_CODE = 4'd8;

  // brightness clamp
  localparam logic [7:0] PERCENT_MAX = 8'd100;

  // factor = p*255/100 = p*51/20, taken as (p*51*3277) >> 16, exact for p up to 100
  localparam int FACTOR_MUL   = 51 * 3277;
  localparam int FACTOR_SHIFT = 16;

  // action codes
  localparam logic [1:0] ACT_SET       = 2'd0;
  localparam logic [1:0] ACT_ALL_OFF   = 2'd1;
  localparam logic [1:0] ACT_SPI_READY = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] percent;
  } in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] spi_byte;
    logic       frame_last;
    logic       update_pending;
  } out_t;

  // four-bit line code of one colour bit
  function automatic logic [3:0] bit_code(input logic b);
    return b ? BIT_ONE_CODE : BIT_ZERO_CODE;
  endfunction

  // floor(x/255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/rgbspi_ram.sv
`default_nettype none

module rgbspi_ram import rgbspi_pkg::*; #(
  parameter int WIDTH = COLOUR_W,
  parameter int DEPTH = LEDS_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/rgb_led_chain_spi_frame_encoder.sv
`default_nettype none

// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | in_data  (in_t: action, index, colour, percent)
// out_    | output    | out_valid/out_stall | out_data (out_t: spi byte, flags)
//
// one transaction is worked at a time; the result sits in an output register so
// the next transaction is taken while it waits
// set in range: 8-step bit-serial scaling, store write; spi ready: emit, with a fetch
// first when a new led word is read from the snapshot memory, and a store to snapshot
// copy at frame start; all off, out of range set, unused code: straight to the output
// register; reset: synchronous, no clearing pass

module rgb_led_chain_spi_frame_encoder import rgbspi_pkg::*; #(
  parameter int LEDS        = LEDS_DEFAULT,
  parameter int RESET_BYTES = RESET_BYTES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int LW = (LEDS > 1) ? $clog2(LEDS) : 1;
  localparam int CW = $clog2(LEDS + 1);
  localparam int RW = (RESET_BYTES > 1) ? $clog2(RESET_BYTES) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_COPY  = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // control state
  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            sending_r, sending_nxt;
  logic            dirty_r, dirty_nxt;
  logic [LEDS-1:0] store_vld_r, store_vld_nxt;
  logic [LW-1:0]   led_r, led_nxt;
  logic [3:0]      within_r, within_nxt;
  logic [RW-1:0]   rst_cnt_r, rst_cnt_nxt;
  logic            data_phase_r, data_phase_nxt;
  logic            copy_wr_r, copy_wr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [2:0]      bit_cnt_r, bit_cnt_nxt;

  // payload state
  logic [LW-1:0]   copy_addr_r, copy_addr_nxt;
  logic [LW-1:0]   idx_r, idx_nxt;
  logic [7:0]      fac_r, fac_nxt;
  logic [7:0]      g_r, g_nxt, r_r, r_nxt, b_r, b_nxt;
  logic [15:0]     acc_g_r, acc_g_nxt, acc_r_r, acc_r_nxt, acc_b_r, acc_b_nxt;
  logic [23:0]     shreg_r, shreg_nxt;
  logic            res_valid_r, res_valid_nxt;
  logic [7:0]      res_byte_r, res_byte_nxt;
  logic            res_last_r, res_last_nxt;
  out_t            out_data_r, out_data_nxt;

  // memory ports
  logic                store_we;
  logic [COLOUR_W-1:0] store_wdata, store_rdata;
  logic [COLOUR_W-1:0] snap_wdata, snap_rdata;

  // scratch
  logic [6:0]  pct;
  logic [23:0] fac_prod;
  logic        idx_ok;
  logic [23:0] word;
  logic        in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // brightness factor from clamped percent
  assign pct      = (in_data.percent > PERCENT_MAX) ? PERCENT_MAX[6:0] : in_data.percent[6:0];
  assign fac_prod = 24'(pct) * 24'(FACTOR_MUL);
  assign idx_ok   = ({1'b0, in_data.led_index} < 9'(LEDS));

  // led word for the current byte: fresh from memory on the first byte of an led
  assign word = (within_r == WITHIN_FIRST) ? snap_rdata : shreg_r;

  // scaled colour word
  assign store_we    = (state_r == S_WRITE);
  assign store_wdata = {div255(acc_g_r), div255(acc_r_r), div255(acc_b_r)};

  // entries not written since the last all off read as zero
  assign snap_wdata  = store_vld_r[copy_addr_r] ? store_rdata : '0;

  rgbspi_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(LEDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_we),
    .wr_addr(idx_r),
    .wr_data(store_wdata),
    .rd_addr(cnt_r[LW-1:0]),
    .rd_data(store_rdata)
  );

  rgbspi_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(LEDS)
  ) u_snap (
    .clk    (clk),
    .wr_en  (copy_wr_r),
    .wr_addr(copy_addr_r),
    .wr_data(snap_wdata),
    .rd_addr(led_r),
    .rd_data(snap_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    sending_nxt    = sending_r;
    dirty_nxt      = dirty_r;
    store_vld_nxt  = store_vld_r;
    led_nxt        = led_r;
    within_nxt     = within_r;
    rst_cnt_nxt    = rst_cnt_r;
    data_phase_nxt = data_phase_r;
    copy_wr_nxt    = 1'b0;
    cnt_nxt        = cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    copy_addr_nxt  = copy_addr_r;
    idx_nxt        = idx_r;
    fac_nxt        = fac_r;
    g_nxt          = g_r;
    r_nxt          = r_r;
    b_nxt          = b_r;
    acc_g_nxt      = acc_g_r;
    acc_r_nxt      = acc_r_r;
    acc_b_nxt      = acc_b_r;
    shreg_nxt      = shreg_r;
    res_valid_nxt  = res_valid_r;
    res_byte_nxt   = res_byte_r;
    res_last_nxt   = res_last_r;
    out_data_nxt   = out_data_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_valid_nxt = 1'b0;
          res_byte_nxt  = '0;
          res_last_nxt  = 1'b0;
          idx_nxt       = in_data.led_index[LW-1:0];
          fac_nxt       = fac_prod[FACTOR_SHIFT +: 8];
          g_nxt         = in_data.green;
          r_nxt         = in_data.red;
          b_nxt         = in_data.blue;
          acc_g_nxt     = '0;
          acc_r_nxt     = '0;
          acc_b_nxt     = '0;
          bit_cnt_nxt   = '0;
          cnt_nxt       = '0;
          state_nxt     = S_DONE;
          case (in_data.action)
            ACT_SET: begin
              if (idx_ok) begin
                state_nxt = S_MUL;
              end
            end
            ACT_ALL_OFF: begin
              store_vld_nxt = '0;
              dirty_nxt     = 1'b1;
            end
            ACT_SPI_READY: begin
              if (!sending_r && dirty_r) begin
                state_nxt = S_COPY;
              end else if (sending_r) begin
                state_nxt = (data_phase_r && within_r == WITHIN_FIRST) ? S_FETCH : S_EMIT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // bit-serial shift and add, colour msb first
      S_MUL: begin
        acc_g_nxt   = {acc_g_r[14:0], 1'b0} + (g_r[7] ? 16'(fac_r) : 16'd0);
        acc_r_nxt   = {acc_r_r[14:0], 1'b0} + (r_r[7] ? 16'(fac_r) : 16'd0);
        acc_b_nxt   = {acc_b_r[14:0], 1'b0} + (b_r[7] ? 16'(fac_r) : 16'd0);
        g_nxt       = {g_r[6:0], 1'b0};
        r_nxt       = {r_r[6:0], 1'b0};
        b_nxt       = {b_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        store_vld_nxt[idx_r] = 1'b1;
        dirty_nxt            = 1'b1;
        state_nxt            = S_DONE;
      end

      // store to snapshot sweep, each write lands in the cycle after its read
      S_COPY: begin
        if (cnt_r < CW'(LEDS)) begin
          copy_wr_nxt   = 1'b1;
          copy_addr_nxt = cnt_r[LW-1:0];
          cnt_nxt       = cnt_r + CW'(1);
        end else begin
          sending_nxt = 1'b1;
          dirty_nxt   = 1'b0;
          state_nxt   = S_FETCH;
        end
      end

      S_FETCH: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        res_valid_nxt = 1'b1;
        if (data_phase_r) begin
          res_byte_nxt = {bit_code(word[23]), bit_code(word[22])};
          shreg_nxt    = {word[21:0], 2'b00};
          if (within_r == WITHIN_LAST) begin
            within_nxt = WITHIN_FIRST;
            if (led_r == LW'(LEDS - 1)) begin
              led_nxt        = '0;
              data_phase_nxt = 1'b0;
            end else begin
              led_nxt = led_r + LW'(1);
            end
          end else begin
            within_nxt = within_r + 4'd1;
          end
        end else begin
          res_byte_nxt = '0;
          if (rst_cnt_r == RW'(RESET_BYTES - 1)) begin
            res_last_nxt   = 1'b1;
            sending_nxt    = 1'b0;
            rst_cnt_nxt    = '0;
            data_phase_nxt = 1'b1;
          end else begin
            rst_cnt_nxt = rst_cnt_r + RW'(1);
          end
        end
        state_nxt = S_DONE;
      end

      // hand result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.byte_valid     = res_valid_r;
          out_data_nxt.spi_byte       = res_byte_r;
          out_data_nxt.frame_last     = res_last_r;
          out_data_nxt.update_pending = dirty_r;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      sending_r    <= 1'b0;
      dirty_r      <= 1'b1;
      store_vld_r  <= '0;
      led_r        <= '0;
      within_r     <= WITHIN_FIRST;
      rst_cnt_r    <= '0;
      data_phase_r <= 1'b1;
      copy_wr_r    <= 1'b0;
      cnt_r        <= '0;
      bit_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      sending_r    <= sending_nxt;
      dirty_r      <= dirty_nxt;
      store_vld_r  <= store_vld_nxt;
      led_r        <= led_nxt;
      within_r     <= within_nxt;
      rst_cnt_r    <= rst_cnt_nxt;
      data_phase_r <= data_phase_nxt;
      copy_wr_r    <= copy_wr_nxt;
      cnt_r        <= cnt_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_addr_r <= copy_addr_nxt;
    idx_r       <= idx_nxt;
    fac_r       <= fac_nxt;
    g_r         <= g_nxt;
    r_r         <= r_nxt;
    b_r         <= b_nxt;
    acc_g_r     <= acc_g_nxt;
    acc_r_r     <= acc_r_nxt;
    acc_b_r     <= acc_b_nxt;
    shreg_r     <= shreg_nxt;
    res_valid_r <= res_valid_nxt;
    res_byte_r  <= res_byte_nxt;
    res_last_r  <= res_last_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire
